[design/bpa_pkg.sv]
`default_nettype none
package bpa_pkg;

    localparam int MAX_PAGES_DEF   = 4096;
    localparam int TOP_ORDER_DEF   = 12;
    localparam int ORD_W           = 4;
    localparam int COUNT_W         = 13;
    localparam int PAGE_ADDR_W     = 32;
    localparam int CFG_IDX_W       = 2;
    localparam int CFG_DATA_W      = 32;
    localparam logic [ORD_W-1:0] ZONE_ORDER_RESET = 4'd12;

    localparam logic [CFG_IDX_W-1:0] CFG_BASE_PAGE  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ZONE_ORDER = 2'd1;

    typedef enum logic [1:0] {
        ST_OK  = 2'd0,
        ST_OOM = 2'd1,
        ST_BAD = 2'd2
    } status_t;

    typedef struct packed {
        logic                   bad;
        logic [ORD_W-1:0]       ord;
        logic [PAGE_ADDR_W-1:0] off;
    } free_chk_t;

    // smallest o with 2^o >= c (c of zero gives zero)
    function automatic logic [ORD_W-1:0] order_of(input logic [COUNT_W-1:0] c);
        logic [ORD_W-1:0] o;
        o = '0;
        for (int i = COUNT_W; i >= 0; i--) begin
            if ({1'b0, c} <= ((COUNT_W+1)'(1) << i)) begin
                o = ORD_W'(i);
            end
        end
        return o;
    endfunction

endpackage
`default_nettype wire

[design/bpa_free_check.sv]
`default_nettype none
module bpa_free_check #(
    parameter int MAX_PAGES = bpa_pkg::MAX_PAGES_DEF
) (
    input  wire logic [bpa_pkg::COUNT_W-1:0]           page_count,
    input  wire logic [bpa_pkg::PAGE_ADDR_W-1:0]       first_page,
    input  wire logic [bpa_pkg::PAGE_ADDR_W-1:0]       base_page,
    input  wire logic [bpa_pkg::ORD_W-1:0]             zone_ord,
    input  wire logic [$clog2(MAX_PAGES):0]            free_count,
    output bpa_pkg::free_chk_t                         chk
);
    localparam int LINK_W = $clog2(MAX_PAGES) + 1;

    logic [bpa_pkg::PAGE_ADDR_W:0]   off_ext;
    logic [bpa_pkg::PAGE_ADDR_W:0]   zsize_ext;
    logic [LINK_W:0]                 zsize_fc;
    logic [bpa_pkg::ORD_W-1:0]       ord;
    logic                            not_pow2;

    always_comb begin
        ord       = bpa_pkg::order_of(page_count);
        off_ext   = {1'b0, first_page - base_page};
        zsize_ext = (bpa_pkg::PAGE_ADDR_W+1)'(1) << zone_ord;
        zsize_fc  = (LINK_W+1)'(1) << zone_ord;
        not_pow2  = (page_count == '0) ||
                    ((page_count & (page_count - 1'b1)) != '0);
        chk.ord   = ord;
        chk.off   = off_ext[bpa_pkg::PAGE_ADDR_W-1:0];
        chk.bad   = (first_page < base_page) || not_pow2 || (ord > zone_ord) ||
                    ((off_ext + (bpa_pkg::PAGE_ADDR_W+1)'(page_count)) > zsize_ext) ||
                    ((off_ext[bpa_pkg::COUNT_W-1:0] & (page_count - 1'b1)) != '0) ||
                    (({1'b0, free_count} + (LINK_W+1)'(page_count)) > zsize_fc);
    end

endmodule
`default_nettype wire

[design/buddy_page_allocator.sv]
`default_nettype none
// Binary buddy page allocator.
// Request channel s_*: s_kind 0 allocates s_page_count pages (rounded up to a
// power of two), 1 frees the block at s_first_page. Every item that no
// zone_order write cuts off gives exactly one result on m_*: m_status (ok,
// out of memory, invalid free) and m_granted_page. Results sit in an output
// register; a stalled m_ready holds the result, and the next item is taken
// meanwhile but finishes only once the register has been emptied.
// Items are handled one at a time. Allocate searches upward for a free order,
// pops a block and splits it one level at a time; out of memory is found at
// acceptance or in the search. Free checks the request (an invalid free ends
// there), merges with its buddy level by level and pushes the block. Each
// step is a dependent read-modify-write on the link and pair memories.
// Reset and every zone_order write start a clearing pass over all MAX_PAGES
// memory entries; no item is accepted during it, configuration writes are.
// base_page writes change only the address mapping.
module buddy_page_allocator #(
    parameter int MAX_PAGES = bpa_pkg::MAX_PAGES_DEF,
    parameter int TOP_ORDER = bpa_pkg::TOP_ORDER_DEF
) (
    input  wire logic                               aclk,
    input  wire logic                               aresetn,
    input  wire logic                               cfg_wr_en,
    input  wire logic [bpa_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  wire logic [bpa_pkg::CFG_DATA_W-1:0]     cfg_wr_data,
    input  wire logic                               s_valid,
    output logic                                    s_ready,
    input  wire logic                               s_kind,
    input  wire logic [bpa_pkg::COUNT_W-1:0]        s_page_count,
    input  wire logic [bpa_pkg::PAGE_ADDR_W-1:0]    s_first_page,
    output logic                                    m_valid,
    input  wire logic                               m_ready,
    output logic [1:0]                              m_status,
    output logic [bpa_pkg::PAGE_ADDR_W-1:0]         m_granted_page
);
    localparam int PAGE_W  = $clog2(MAX_PAGES);
    localparam int LINK_W  = PAGE_W + 1;
    localparam int LOG_MAX = $clog2(MAX_PAGES + 1) - 1;
    localparam int HEAD_W  = (TOP_ORDER > 0) ? $clog2(TOP_ORDER + 1) : 1;
    localparam int ORD_W   = bpa_pkg::ORD_W;
    localparam logic [LINK_W-1:0] EMPTY = LINK_W'(MAX_PAGES);

    typedef enum logic [12:0] {
        S_CLEAR  = 13'b0000000000001,
        S_IDLE   = 13'b0000000000010,
        S_SEARCH = 13'b0000000000100,
        S_POP    = 13'b0000000001000,
        S_POP2   = 13'b0000000010000,
        S_SPLIT  = 13'b0000000100000,
        S_FCHK   = 13'b0000001000000,
        S_MRD    = 13'b0000010000000,
        S_MCHK   = 13'b0000100000000,
        S_UNL    = 13'b0001000000000,
        S_PUSH   = 13'b0010000000000,
        S_PUSH2  = 13'b0100000000000,
        S_DONE   = 13'b1000000000000
    } state_t;

    function automatic logic [PAGE_W-1:0] pair_addr(input logic [ORD_W-1:0] ord,
                                                   input logic [PAGE_W-1:0] blk);
        logic [LINK_W:0] m;
        logic [LINK_W:0] a;
        m = ((LINK_W+1)'(2) << ord) - 1'b1;
        a = ((LINK_W+1)'(blk) & ~m) | (m >> 1);
        return a[PAGE_W-1:0];
    endfunction

    state_t                         state_reg, state_next;
    logic [LINK_W-1:0]              clr_cnt_reg, clr_cnt_next;
    logic [ORD_W-1:0]               zo_reg, zo_next;
    logic [bpa_pkg::PAGE_ADDR_W-1:0] base_reg;
    logic [LINK_W-1:0]              heads_reg [TOP_ORDER+1];
    logic [LINK_W-1:0]              heads_next [TOP_ORDER+1];
    logic [LINK_W-1:0]              free_reg, free_next;
    logic [bpa_pkg::COUNT_W-1:0]    count_reg;
    logic [bpa_pkg::PAGE_ADDR_W-1:0] start_reg;
    logic [ORD_W-1:0]               ord_reg, ord_next;
    logic [ORD_W-1:0]               req_reg, req_next;
    logic [PAGE_W-1:0]              blk_reg, blk_next;
    logic [PAGE_W-1:0]              bud_reg, bud_next;
    bpa_pkg::status_t               stat_reg, stat_next;
    logic [bpa_pkg::PAGE_ADDR_W-1:0] grant_reg, grant_next;
    logic                           m_valid_reg, m_valid_next;
    logic [1:0]                     m_status_reg;
    logic [bpa_pkg::PAGE_ADDR_W-1:0] m_grant_reg;

    logic [LINK_W-1:0] next_mem [MAX_PAGES];
    logic [LINK_W-1:0] prev_mem [MAX_PAGES];
    logic              pair_mem [MAX_PAGES];

    logic              nx_we, pv_we, pr_we;
    logic [PAGE_W-1:0] nx_wa, pv_wa, pr_wa, nx_ra, pv_ra, pr_ra;
    logic [LINK_W-1:0] nx_wd, pv_wd, nx_rd, pv_rd;
    logic              pr_wd, pr_rd;

    logic              zone_wr;
    logic [ORD_W-1:0]  zo_eff;
    bpa_pkg::free_chk_t chk;

    bpa_free_check #(.MAX_PAGES(MAX_PAGES)) u_chk (
        .page_count (count_reg),
        .first_page (start_reg),
        .base_page  (base_reg),
        .zone_ord   (zo_reg),
        .free_count (free_reg),
        .chk        (chk)
    );

    assign zone_wr = cfg_wr_en && (cfg_index == bpa_pkg::CFG_ZONE_ORDER);

    always_comb begin
        zo_eff = cfg_wr_data[ORD_W-1:0];
        if (zo_eff > ORD_W'(TOP_ORDER)) zo_eff = ORD_W'(TOP_ORDER);
        if (zo_eff > ORD_W'(LOG_MAX))   zo_eff = ORD_W'(LOG_MAX);
    end

    always_ff @(posedge aclk) begin
        if (nx_we) next_mem[nx_wa] <= nx_wd;
        if (pv_we) prev_mem[pv_wa] <= pv_wd;
        if (pr_we) pair_mem[pr_wa] <= pr_wd;
        nx_rd <= next_mem[nx_ra];
        pv_rd <= prev_mem[pv_ra];
        pr_rd <= pair_mem[pr_ra];
    end

    always_comb begin
        logic [LINK_W-1:0] h;
        logic [LINK_W-1:0] n;
        logic [LINK_W-1:0] p;
        logic [ORD_W-1:0]  j;
        logic [ORD_W-1:0]  o;
        logic [bpa_pkg::COUNT_W-1:0] c;
        h = heads_reg[ord_reg[HEAD_W-1:0]];
        n = nx_rd;
        p = pv_rd;
        j = ord_reg - 1'b1;
        c = (s_page_count == '0) ? bpa_pkg::COUNT_W'(1) : s_page_count;
        o = bpa_pkg::order_of(c);
        state_next   = state_reg;
        clr_cnt_next = clr_cnt_reg;
        zo_next      = zo_reg;
        heads_next   = heads_reg;
        free_next    = free_reg;
        ord_next     = ord_reg;
        req_next     = req_reg;
        blk_next     = blk_reg;
        bud_next     = bud_reg;
        stat_next    = stat_reg;
        grant_next   = grant_reg;
        m_valid_next = m_valid_reg && !m_ready;
        s_ready      = (state_reg == S_IDLE);
        nx_we = 1'b0; nx_wa = blk_reg; nx_wd = EMPTY;
        pv_we = 1'b0; pv_wa = blk_reg; pv_wd = EMPTY;
        pr_we = 1'b0; pr_wa = pair_addr(ord_reg, blk_reg); pr_wd = 1'b0;
        nx_ra = h[PAGE_W-1:0];
        pv_ra = bud_reg;
        pr_ra = pair_addr(ord_reg, blk_reg);

        unique case (state_reg)
            S_CLEAR: begin
                nx_we = 1'b1; pv_we = 1'b1; pr_we = 1'b1;
                nx_wa = clr_cnt_reg[PAGE_W-1:0];
                pv_wa = clr_cnt_reg[PAGE_W-1:0];
                pr_wa = clr_cnt_reg[PAGE_W-1:0];
                pr_wd = (LINK_W'(clr_cnt_reg[PAGE_W-1:0]) ==
                         (LINK_W'(1) << zo_reg) - 1'b1);
                // heads and free count of the reset image follow the zone order
                if (clr_cnt_reg == '0) begin
                    free_next = LINK_W'(1) << zo_reg;
                    for (int i = 0; i <= TOP_ORDER; i++) begin
                        heads_next[i] = (ORD_W'(i) == zo_reg) ? '0 : EMPTY;
                    end
                end
                clr_cnt_next = clr_cnt_reg + 1'b1;
                if (clr_cnt_reg == LINK_W'(MAX_PAGES - 1)) state_next = S_IDLE;
            end
            S_IDLE: begin
                if (s_valid) begin
                    if (s_kind) begin
                        state_next = S_FCHK;
                    end else if ((o > zo_reg) || ((LINK_W'(1) << o) > free_reg)) begin
                        stat_next  = bpa_pkg::ST_OOM;
                        grant_next = '0;
                        state_next = S_DONE;
                    end else begin
                        ord_next   = o;
                        req_next   = o;
                        state_next = S_SEARCH;
                    end
                end
            end
            S_SEARCH: begin
                if (h < LINK_W'(MAX_PAGES)) begin
                    state_next = S_POP;
                end else if (ord_reg >= zo_reg) begin
                    stat_next  = bpa_pkg::ST_OOM;
                    grant_next = '0;
                    state_next = S_DONE;
                end else begin
                    ord_next = ord_reg + 1'b1;
                end
            end
            S_POP: begin
                blk_next = h[PAGE_W-1:0];
                pr_we = 1'b1;
                pr_wa = pair_addr(ord_reg, h[PAGE_W-1:0]);
                pr_wd = 1'b0;
                state_next = S_POP2;
            end
            S_POP2: begin
                heads_next[ord_reg[HEAD_W-1:0]] = (n < LINK_W'(MAX_PAGES)) ? n : EMPTY;
                if (n < LINK_W'(MAX_PAGES)) begin
                    pv_we = 1'b1; pv_wa = n[PAGE_W-1:0]; pv_wd = EMPTY;
                end
                if (ord_reg > req_reg) begin
                    state_next = S_SPLIT;
                end else begin
                    free_next  = free_reg - (LINK_W'(1) << req_reg);
                    stat_next  = bpa_pkg::ST_OK;
                    grant_next = base_reg + bpa_pkg::PAGE_ADDR_W'(blk_reg);
                    state_next = S_DONE;
                end
            end
            S_SPLIT: begin
                pr_we = 1'b1; pr_wa = pair_addr(j, blk_reg); pr_wd = 1'b1;
                nx_we = 1'b1; nx_wa = blk_reg + (PAGE_W'(1) << j); nx_wd = EMPTY;
                pv_we = 1'b1; pv_wa = blk_reg + (PAGE_W'(1) << j); pv_wd = EMPTY;
                heads_next[j[HEAD_W-1:0]] = LINK_W'(blk_reg + (PAGE_W'(1) << j));
                ord_next = j;
                if (j == req_reg) begin
                    free_next  = free_reg - (LINK_W'(1) << req_reg);
                    stat_next  = bpa_pkg::ST_OK;
                    grant_next = base_reg + bpa_pkg::PAGE_ADDR_W'(blk_reg);
                    state_next = S_DONE;
                end
            end
            S_FCHK: begin
                if (chk.bad) begin
                    stat_next  = bpa_pkg::ST_BAD;
                    grant_next = '0;
                    state_next = S_DONE;
                end else begin
                    free_next  = free_reg + LINK_W'(count_reg);
                    blk_next   = chk.off[PAGE_W-1:0];
                    ord_next   = chk.ord;
                    state_next = S_MRD;
                end
            end
            S_MRD: begin
                state_next = (ord_reg < zo_reg) ? S_MCHK : S_PUSH;
            end
            S_MCHK: begin
                if (pr_rd) begin
                    pr_we    = 1'b1; pr_wd = 1'b0;
                    bud_next = blk_reg ^ (PAGE_W'(1) << ord_reg);
                    nx_ra    = blk_reg ^ (PAGE_W'(1) << ord_reg);
                    pv_ra    = blk_reg ^ (PAGE_W'(1) << ord_reg);
                    state_next = S_UNL;
                end else begin
                    state_next = S_PUSH;
                end
            end
            S_UNL: begin
                if (n < LINK_W'(MAX_PAGES)) begin
                    pv_we = 1'b1; pv_wa = n[PAGE_W-1:0]; pv_wd = p;
                end
                if (p < LINK_W'(MAX_PAGES)) begin
                    nx_we = 1'b1; nx_wa = p[PAGE_W-1:0]; nx_wd = n;
                end
                if (h == LINK_W'(bud_reg)) begin
                    heads_next[ord_reg[HEAD_W-1:0]] = (n < LINK_W'(MAX_PAGES)) ? n : EMPTY;
                end
                blk_next   = blk_reg & ~((PAGE_W'(2) << ord_reg) - 1'b1);
                ord_next   = ord_reg + 1'b1;
                state_next = S_MRD;
            end
            S_PUSH: begin
                pr_we = 1'b1; pr_wd = 1'b1;
                if (h < LINK_W'(MAX_PAGES)) begin
                    pv_we = 1'b1; pv_wa = h[PAGE_W-1:0]; pv_wd = LINK_W'(blk_reg);
                end
                nx_we = 1'b1; nx_wa = blk_reg;
                nx_wd = (h < LINK_W'(MAX_PAGES)) ? h : EMPTY;
                state_next = S_PUSH2;
            end
            S_PUSH2: begin
                pv_we = 1'b1; pv_wa = blk_reg; pv_wd = EMPTY;
                heads_next[ord_reg[HEAD_W-1:0]] = LINK_W'(blk_reg);
                stat_next  = bpa_pkg::ST_OK;
                grant_next = '0;
                state_next = S_DONE;
            end
            S_DONE: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default: state_next = S_CLEAR;
        endcase

        // zone resize: restart from the reset image
        if (zone_wr) begin
            zo_next      = zo_eff;
            clr_cnt_next = '0;
            free_next    = LINK_W'(1) << zo_eff;
            for (int i = 0; i <= TOP_ORDER; i++) begin
                heads_next[i] = (ORD_W'(i) == zo_eff) ? '0 : EMPTY;
            end
            state_next = S_CLEAR;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_CLEAR;
            clr_cnt_reg <= '0;
            zo_reg      <= (bpa_pkg::ZONE_ORDER_RESET > ORD_W'(TOP_ORDER)) ?
                           ((ORD_W'(TOP_ORDER) > ORD_W'(LOG_MAX)) ? ORD_W'(LOG_MAX)
                                                                 : ORD_W'(TOP_ORDER)) :
                           ((bpa_pkg::ZONE_ORDER_RESET > ORD_W'(LOG_MAX)) ? ORD_W'(LOG_MAX)
                                                           : bpa_pkg::ZONE_ORDER_RESET);
            base_reg    <= '0;
            m_valid_reg <= 1'b0;
            for (int i = 0; i <= TOP_ORDER; i++) begin
                heads_reg[i] <= (i == 0 && TOP_ORDER == 0) ? '0 : EMPTY;
            end
            free_reg    <= '0;
        end else begin
            state_reg   <= state_next;
            clr_cnt_reg <= clr_cnt_next;
            zo_reg      <= zo_next;
            m_valid_reg <= m_valid_next;
            heads_reg   <= heads_next;
            free_reg    <= free_next;
            if (cfg_wr_en && cfg_index == bpa_pkg::CFG_BASE_PAGE) begin
                base_reg <= cfg_wr_data;
            end
        end
    end

    always_ff @(posedge aclk) begin
        ord_reg   <= ord_next;
        req_reg   <= req_next;
        blk_reg   <= blk_next;
        bud_reg   <= bud_next;
        stat_reg  <= stat_next;
        grant_reg <= grant_next;
        if (s_valid && s_ready) begin
            count_reg <= s_page_count;
            start_reg <= s_first_page;
        end
        if (state_reg == S_DONE && (!m_valid_reg || m_ready)) begin
            m_status_reg <= stat_reg;
            m_grant_reg  <= grant_reg;
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_status       = m_status_reg;
    assign m_granted_page = m_grant_reg;

endmodule
`default_nettype wire
